### rtl/lls_pkg.sv
// Shared package for the least-loaded server dispatcher.
// Holds sizes, the microcode control word, the control program and helpers.
// No dependencies; every other file imports it.
package lls_pkg;

    localparam int MAX_SERVERS = 64;
    localparam int LOAD_W      = 32;
    localparam int TIME_W      = 16;
    localparam int SRV_W       = 7;
    localparam int IDX_W       = $clog2(MAX_SERVERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int STEP_W      = 3;

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [LOAD_W-1:0] t_load;

    typedef enum logic [2:0] {
        UOP_LOAD,
        UOP_SCAN,
        UOP_DRAIN,
        UOP_ADD,
        UOP_FINISH
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ACC,
        COND_NOT_LAST,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_acc;
        logic last_addr;
        logic out_busy;
    } t_lls_stat;

    localparam t_step ST_IDLE   = t_step'(0);
    localparam t_step ST_SCAN   = t_step'(1);
    localparam t_step ST_DRAIN  = t_step'(2);
    localparam t_step ST_ADD    = t_step'(3);
    localparam t_step ST_FINISH = t_step'(4);

    // A taken jump goes to target; otherwise the step counter advances by one.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            ST_IDLE:   w = '{op: UOP_LOAD,   cond: COND_NO_ACC,   target: ST_IDLE};
            ST_SCAN:   w = '{op: UOP_SCAN,   cond: COND_NOT_LAST, target: ST_SCAN};
            ST_DRAIN:  w = '{op: UOP_DRAIN,  cond: COND_NEVER,    target: ST_IDLE};
            ST_ADD:    w = '{op: UOP_ADD,    cond: COND_OUT_BUSY, target: ST_ADD};
            ST_FINISH: w = '{op: UOP_FINISH, cond: COND_ALWAYS,   target: ST_IDLE};
            default:   w = '{op: UOP_FINISH, cond: COND_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

    // Server count zero acts as one; counts above the array size saturate.
    function automatic t_cnt clamp_count(input logic [SRV_W-1:0] raw);
        t_cnt c;
        if (raw == '0) begin
            c = t_cnt'(1);
        end else if (32'(raw) > 32'(MAX_SERVERS)) begin
            c = t_cnt'(MAX_SERVERS);
        end else begin
            c = t_cnt'(raw);
        end
        return c;
    endfunction

endpackage

### rtl/lls_seq.sv
// Microcode sequencer for the dispatcher: step counter, control ROM, jump logic.
// Depends on lls_pkg for the control word, status struct and program.
module lls_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lls_pkg::t_lls_stat i_stat,
    output lls_pkg::t_uop      o_uop
);
    import lls_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    always_comb begin
        w_word = ucode_rom(r_step);
        unique case (w_word.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_NO_ACC:   w_take = !i_stat.in_acc;
            COND_NOT_LAST: w_take = !i_stat.last_addr;
            COND_OUT_BUSY: w_take = i_stat.out_busy;
            default:       w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.target : r_step + t_step'(1);
        o_uop  = w_word.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/least_loaded_server_dispatch.sv
// Top level of the least-loaded server dispatcher: busy-time memory and datapath.
// Depends on lls_pkg and on lls_seq, which steps the control program.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  input    | i_valid / o_stall        | i_service_time, i_last_of_case
//  output   | o_valid / i_stall        | o_assigned_server, o_next_server
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data (num_servers)
//
// Each accepted item passes the scan, drain, add and finish steps before another is taken;
// the scan reads the clamped count of busy times, one per cycle, from the single read port.
// The scan tracks the least and second-least entries, so the following server needs no
// second pass. Reset is synchronous and leaves every busy time at zero through valid bits.
// A held output delays the memory write-back step until the output register is free.
module least_loaded_server_dispatch (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [lls_pkg::TIME_W-1:0] i_service_time,
    input  logic                      i_last_of_case,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lls_pkg::SRV_W-1:0] o_assigned_server,
    output logic [lls_pkg::SRV_W-1:0] o_next_server,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lls_pkg::SRV_W-1:0] i_cfg_data
);
    import lls_pkg::*;

    t_uop       w_uop;
    t_lls_stat  w_stat;
    logic       w_acc;

    logic [SRV_W-1:0]       r_num;
    t_cnt                   r_cnt;
    logic [TIME_W-1:0]      r_time;
    logic                   r_last;
    t_idx                   r_addr;
    logic                   r_pend;
    t_idx                   r_pidx;
    logic                   r_first;
    t_load                  r_b;
    t_idx                   r_bi;
    t_load                  r_s;
    t_idx                   r_si;
    logic                   r_sv;
    t_load                  n_b;
    t_idx                   n_bi;
    t_load                  n_s;
    t_idx                   n_si;
    logic                   n_sv;
    t_load                  r_newv;
    t_load                  r_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_vld;
    t_load                  r_rd_data;
    logic                   r_rd_vld;
    logic                   r_ovld;
    logic [SRV_W-1:0]       r_asg;
    logic [SRV_W-1:0]       r_nxt;
    t_load                  w_x;
    logic [LOAD_W:0]        w_sum;
    t_idx                   w_next_idx;

    lls_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    assign o_stall     = (w_uop != UOP_LOAD);
    assign w_acc       = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_stat.in_acc    = w_acc;
    assign w_stat.last_addr = (t_cnt'(r_addr) == r_cnt - t_cnt'(1));
    assign w_stat.out_busy  = r_ovld && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= SRV_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num <= i_cfg_data;
        end
    end

    // Busy-time memory; an entry whose valid bit is clear reads as zero.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
        r_rd_vld  <= r_vld[r_addr];
        if (w_uop == UOP_FINISH) begin
            r_mem[r_bi] <= r_newv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_uop == UOP_FINISH) begin
            if (r_last) begin
                r_vld <= '0;
            end else begin
                r_vld[r_bi] <= 1'b1;
            end
        end
    end

    assign w_x = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        n_b  = r_b;
        n_bi = r_bi;
        n_s  = r_s;
        n_si = r_si;
        n_sv = r_sv;
        if (r_pend) begin
            priority if (r_first) begin
                n_b  = w_x;
                n_bi = r_pidx;
                n_sv = 1'b0;
            end else if (w_x < r_b) begin
                n_s  = r_b;
                n_si = r_bi;
                n_sv = 1'b1;
                n_b  = w_x;
                n_bi = r_pidx;
            end else if (!r_sv || w_x < r_s) begin
                n_s  = w_x;
                n_si = r_pidx;
                n_sv = 1'b1;
            end else begin
                n_sv = r_sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            unique case (w_uop)
                UOP_LOAD: begin
                    r_pend  <= 1'b0;
                    r_first <= 1'b1;
                end
                UOP_SCAN: begin
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        r_first <= 1'b0;
                    end
                end
                UOP_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_first <= 1'b0;
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    assign w_sum = {1'b0, r_b} + (LOAD_W + 1)'(r_time);

    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_bi   <= n_bi;
        r_s    <= n_s;
        r_si   <= n_si;
        r_sv   <= n_sv;
        r_pidx <= r_addr;
        if (w_acc) begin
            r_cnt  <= clamp_count(r_num);
            r_time <= i_service_time;
            r_last <= i_last_of_case;
            r_addr <= '0;
        end else if (w_uop == UOP_SCAN) begin
            r_addr <= r_addr + t_idx'(1);
        end
        if (w_uop == UOP_ADD) begin
            r_newv <= w_sum[LOAD_W] ? '1 : w_sum[LOAD_W-1:0];
        end
    end

    always_comb begin
        priority if (!r_sv) begin
            w_next_idx = r_bi;
        end else if (r_newv < r_s) begin
            w_next_idx = r_bi;
        end else if (r_newv == r_s && r_bi < r_si) begin
            w_next_idx = r_bi;
        end else begin
            w_next_idx = r_si;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_uop == UOP_FINISH) begin
            r_ovld <= 1'b1;
        end else if (r_ovld && !i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop == UOP_FINISH) begin
            r_asg <= SRV_W'(t_cnt'(r_bi) + t_cnt'(1));
            r_nxt <= SRV_W'(t_cnt'(w_next_idx) + t_cnt'(1));
        end
    end

    assign o_valid           = r_ovld;
    assign o_assigned_server = r_asg;
    assign o_next_server     = r_nxt;

endmodule

### rtl/lls_chk.sv
// Port-level checker for the least-loaded server dispatcher, with its bind.
// Depends on lls_pkg for field widths; attaches to least_loaded_server_dispatch.
module lls_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic [lls_pkg::TIME_W-1:0] i_service_time,
    input logic                       i_last_of_case,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [lls_pkg::SRV_W-1:0]  o_assigned_server,
    input logic [lls_pkg::SRV_W-1:0]  o_next_server,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [lls_pkg::SRV_W-1:0]  i_cfg_data
);
    import lls_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    // A held item stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_assigned_server)
                               && $stable(o_next_server))
        else $error("held item changed");

    // Once an item is taken, the block is busy scanning on the next cycle.
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("input taken again without a scan");

    // A new result only appears while the input side is closed.
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while idle");

    // Server numbers start at one.
    a_server_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_assigned_server != '0 && o_next_server != '0)
        else $error("server number zero");

endmodule

bind least_loaded_server_dispatch lls_chk u_lls_chk (.*);

### tb/sv/tb_least_loaded_server_dispatch.sv
// Self-checking testbench for least_loaded_server_dispatch: a queue-fed driver, a clocked
// monitor and an in-bench dispatch predictor that tracks every server's busy time.
// Depends on lls_pkg and the RTL top level; runs directed jobs and random cases.
module tb_least_loaded_server_dispatch;
    import lls_pkg::*;

    typedef struct {
        logic [TIME_W-1:0] service;
        logic              last;
    } t_job;

    typedef struct {
        logic [SRV_W-1:0] assigned;
        logic [SRV_W-1:0] following;
    } t_pick;

    localparam int HOLD_CYCLES = 500;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [TIME_W-1:0]  i_service_time = '0;
    logic               i_last_of_case = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [SRV_W-1:0]   o_assigned_server;
    logic [SRV_W-1:0]   o_next_server;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SRV_W-1:0]   i_cfg_data = '0;

    t_job               pending_jobs[$];
    t_job               cur_job;
    t_pick              expected_picks[$];
    logic [LOAD_W-1:0]  srv_busy [MAX_SERVERS];
    logic [SRV_W-1:0]   srv_count_reg = SRV_W'(1);
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    bit                 pressure_armed = 1'b0;
    bit                 hold_started = 1'b0;
    int                 hold_left = 0;
    int                 mismatch_count = 0;

    least_loaded_server_dispatch uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_service_time   (i_service_time),
        .i_last_of_case   (i_last_of_case),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_assigned_server(o_assigned_server),
        .o_next_server    (o_next_server),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int active_servers();
        int n;
        n = int'(srv_count_reg);
        if (n < 1) begin
            n = 1;
        end else if (n > MAX_SERVERS) begin
            n = MAX_SERVERS;
        end
        return n;
    endfunction

    function automatic int least_busy(input int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++) begin
            if (srv_busy[i] < srv_busy[best]) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void dispatch_job(input t_job j);
        int           n;
        int           pick;
        int           nxt_srv;
        logic [LOAD_W:0] sum;
        t_pick        e;
        n = active_servers();
        pick = least_busy(n);
        sum = {1'b0, srv_busy[pick]} + {{(LOAD_W + 1 - TIME_W){1'b0}}, j.service};
        srv_busy[pick] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        nxt_srv = least_busy(n);
        e.assigned = SRV_W'(pick + 1);
        e.following = SRV_W'(nxt_srv + 1);
        expected_picks.push_back(e);
        if (j.last) begin
            foreach (srv_busy[i]) srv_busy[i] = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                dispatch_job(cur_job);
                offer = 1'b0;
            end
            if (!offer && pending_jobs.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                cur_job = pending_jobs.pop_front();
                offer = 1'b1;
                i_service_time <= cur_job.service;
                i_last_of_case <= cur_job.last;
            end
            i_valid <= offer;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (pressure_armed && !hold_started) begin
                hold_left = HOLD_CYCLES;
                hold_started = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pick e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected item: assigned_server %0d, next_server %0d",
                       o_assigned_server, o_next_server);
                mismatch_count++;
            end else begin
                e = expected_picks.pop_front();
                if (o_assigned_server !== e.assigned) begin
                    $error("assigned_server: expected %0d, actual %0d",
                           e.assigned, o_assigned_server);
                    mismatch_count++;
                end
                if (o_next_server !== e.following) begin
                    $error("next_server: expected %0d, actual %0d",
                           e.following, o_next_server);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_job(input logic [TIME_W-1:0] t, input logic last);
        t_job j;
        j.service = t;
        j.last = last;
        pending_jobs.push_back(j);
    endtask

    task automatic wait_idle();
        while (pending_jobs.size() != 0 || i_valid || expected_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (MAX_SERVERS + 8) @(posedge i_clk);
    endtask

    task automatic write_server_count(input logic [SRV_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        srv_count_reg = value;
    endtask

    task automatic queue_random_cases(input int count);
        int pushed;
        int len;
        logic [TIME_W-1:0] t;
        logic last;
        pushed = 0;
        while (pushed < count) begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 3))
                    0: t = TIME_W'($urandom_range(0, 15));
                    1: t = TIME_W'($urandom);
                    2: t = $urandom_range(0, 1) ? '1 : '0;
                    default: t = TIME_W'($urandom_range(0, 255));
                endcase
                if (k == len - 1) begin
                    last = ($urandom_range(0, 9) != 0);
                end else begin
                    last = ($urandom_range(0, 29) == 0);
                end
                push_job(t, last);
                pushed++;
            end
        end
    endtask

    initial begin
        logic [SRV_W-1:0] counts [16];
        counts = '{7'd2, 7'd5, 7'd1, 7'd8, 7'd16, 7'd3, 7'd64, 7'd7,
                   7'd100, 7'd0, 7'd12, 7'd4, 7'd33, 7'd2, 7'd9, 7'd127};
        foreach (srv_busy[i]) srv_busy[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_job('0, 1'b0);
        push_job('1, 1'b0);
        push_job(16'd1, 1'b1);
        wait_idle();
        write_server_count(7'd3);
        push_job('0, 1'b0);
        push_job('0, 1'b0);
        push_job(16'd7, 1'b0);
        push_job(16'd7, 1'b0);
        push_job(16'd7, 1'b0);
        push_job('0, 1'b1);
        wait_idle();
        write_server_count(7'd64);
        push_job('1, 1'b0);
        push_job(16'd1, 1'b0);
        push_job('0, 1'b1);
        wait_idle();
        write_server_count(7'd0);
        push_job(16'd123, 1'b0);
        push_job(16'd456, 1'b1);
        wait_idle();
        write_server_count(7'd127);
        push_job(16'd9, 1'b0);
        push_job('1, 1'b1);
        wait_idle();

        // The server count changes in the middle of a case, so busy times persist.
        write_server_count(7'd4);
        push_job(16'd10, 1'b0);
        push_job(16'd20, 1'b0);
        push_job(16'd30, 1'b0);
        push_job(16'd40, 1'b0);
        wait_idle();
        write_server_count(7'd2);
        push_job(16'd5, 1'b0);
        push_job(16'd5, 1'b0);
        wait_idle();
        write_server_count(7'd6);
        push_job(16'd1, 1'b0);
        push_job(16'd1, 1'b0);
        push_job(16'd1, 1'b1);
        wait_idle();

        for (int p = 0; p < 16; p++) begin
            if (p < 5) begin
                send_idle_pct = 36;
                recv_idle_pct = 52;
            end else if (p < 10) begin
                send_idle_pct = 52;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_server_count(counts[p]);
            if (p == 3) begin
                pressure_armed = 1'b1;
            end
            queue_random_cases(80);
            wait_idle();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_server_count(7'd2);
        for (int k = 0; k < 12; k++) begin
            push_job(TIME_W'($urandom), k == 11);
        end
        wait_idle();

        if (mismatch_count == 0 && expected_picks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### least_loaded_server_dispatch.f
rtl/lls_pkg.sv
rtl/lls_seq.sv
rtl/least_loaded_server_dispatch.sv
rtl/lls_chk.sv
tb/sv/tb_least_loaded_server_dispatch.sv
